@@ hw/rtl/four_channel_pid_speed_control_assert.svh @@
// Assertion macros shared by the PID speed control RTL.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef FOUR_CHANNEL_PID_SPEED_CONTROL_ASSERT_SVH
`define FOUR_CHANNEL_PID_SPEED_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCPID_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/fcpid_pkg.sv @@
// Shared types, constants and helpers for the PID speed control block.
// No dependencies; imported by every RTL module of the block.
package fcpid_pkg;

    localparam int NUM_MOTORS_DEF = 4;
    localparam int MOTOR_CNT_W    = 5;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN_DT = 3'd1,
        REG_DERIV_GAIN_DT = 3'd2,
        REG_BASE_DUTY     = 3'd3,
        REG_DUTY_MAX      = 3'd4,
        REG_INTEG_LIMIT   = 3'd5,
        REG_ENC_FLIP_MASK = 3'd6,
        REG_BRG_FLIP_MASK = 3'd7
    } cfg_reg_t;

    localparam logic [15:0] PROP_GAIN_RST   = 16'd1536;
    localparam logic [15:0] INTEG_GAIN_RST  = 16'd26;
    localparam logic [15:0] DERIV_GAIN_RST  = 16'd26;
    localparam logic [15:0] BASE_DUTY_RST   = 16'd300;
    localparam logic [15:0] DUTY_MAX_RST    = 16'd700;
    localparam logic [14:0] INTEG_LIMIT_RST = 15'd1000;
    localparam logic [3:0]  ENC_FLIP_RST    = 4'd5;
    localparam logic [3:0]  BRG_FLIP_RST    = 4'd10;

    localparam int REQ_UPDATE = 0;

    // Configuration registers as one group.
    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain_dt;
        logic [15:0] deriv_gain_dt;
        logic [15:0] base_duty;
        logic [15:0] duty_max;
        logic [14:0] integ_limit;
        logic [3:0]  enc_flip;
        logic [3:0]  brg_flip;
    } cfg_t;

    // Payload of the stage between the state update and the multipliers.
    typedef struct packed {
        logic               zero_duty;
        logic [1:0]         motor;
        logic               in1;
        logic signed [15:0] count;
        logic               last;
        logic signed [16:0] err;
        logic signed [15:0] esum;
        logic signed [17:0] diff;
    } mid_t;

    // Polarity bit of a motor; motors past the four mask bits read as zero.
    function automatic logic flip_bit(input logic [3:0] mask, input logic [3:0] idx);
        logic b;
        b = 1'b0;
        if (idx < 4'd4) begin
            b = mask[idx[1:0]];
        end
        return b;
    endfunction

endpackage

@@ hw/rtl/fcpid_state.sv @@
// Per-motor controller state (error sum, previous error, direction) and the
// update arithmetic that reads and writes it. Depends on fcpid_pkg.
module fcpid_state
    import fcpid_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF,
    parameter int IDX_W      = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic               stop,
    input  logic               stop_last,
    input  logic [IDX_W-1:0]   stop_idx,
    input  logic [1:0]         motor,
    input  logic signed [15:0] target,
    input  logic signed [15:0] count,
    input  cfg_t               cfg,
    output mid_t               mid
);

    logic signed [15:0] esum_reg [NUM_MOTORS];
    logic signed [16:0] prev_reg [NUM_MOTORS];
    logic               fwd_reg  [NUM_MOTORS];

    logic [IDX_W-1:0]   sel;
    logic               flip_e;
    logic               flip_b;
    logic signed [16:0] cx;
    logic signed [15:0] c_sat;
    logic [16:0]        t_abs;
    logic [15:0]        c_abs;
    logic signed [16:0] err;
    logic signed [17:0] esum_sum;
    logic signed [17:0] lim;
    logic signed [15:0] esum_new;
    logic signed [17:0] diff;
    logic               zero_t;
    logic               fwd_new;

    always_comb begin
        sel    = stop ? stop_idx : IDX_W'(motor);
        flip_e = flip_bit(cfg.enc_flip, 4'(sel));
        flip_b = flip_bit(cfg.brg_flip, 4'(sel));

        cx = flip_e ? -17'(count) : 17'(count);
        if (cx > 17'sd32767) begin
            c_sat = 16'sd32767;
        end else if (cx < -17'sd32767) begin
            c_sat = -16'sd32767;
        end else begin
            c_sat = 16'(cx);
        end

        t_abs = target[15] ? 17'(-17'(target)) : 17'(target);
        c_abs = c_sat[15] ? 16'(-c_sat) : 16'(c_sat);
        err   = $signed(t_abs - {1'b0, c_abs});

        lim      = $signed({3'b000, cfg.integ_limit});
        esum_sum = 18'(esum_reg[sel]) + 18'(err);
        if (esum_sum > lim) begin
            esum_new = 16'(lim);
        end else if (esum_sum < -lim) begin
            esum_new = 16'(-lim);
        end else begin
            esum_new = 16'(esum_sum);
        end

        diff    = 18'(err) - 18'(prev_reg[sel]);
        zero_t  = (target == 16'sd0);
        fwd_new = ~target[15];

        mid.zero_duty = stop | zero_t;
        mid.motor     = 2'(sel);
        mid.in1       = ((stop | zero_t) ? fwd_reg[sel] : fwd_new) ^ flip_b;
        mid.count     = stop ? 16'sd0 : c_sat;
        mid.last      = stop ? stop_last : 1'b1;
        mid.err       = err;
        mid.esum      = esum_new;
        mid.diff      = diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                esum_reg[i] <= '0;
                prev_reg[i] <= '0;
                fwd_reg[i]  <= 1'b1;
            end
        end else if (wr_en) begin
            if (stop) begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    esum_reg[i] <= '0;
                    prev_reg[i] <= '0;
                end
            end else if (zero_t) begin
                esum_reg[sel] <= '0;
                prev_reg[sel] <= '0;
            end else begin
                esum_reg[sel] <= esum_new;
                prev_reg[sel] <= err;
                fwd_reg[sel]  <= fwd_new;
            end
        end
    end

endmodule

@@ hw/rtl/fcpid_duty.sv @@
// Product registers of the P, I and D terms and the duty sum with clamping.
// Depends on fcpid_pkg.
module fcpid_duty
    import fcpid_pkg::*;
(
    input  logic        aclk,
    input  logic        load,
    input  mid_t        mid,
    input  cfg_t        cfg,
    output logic [15:0] duty
);

    localparam int TOT_W = 38;

    logic signed [33:0]      p_reg;
    logic signed [32:0]      i_reg;
    logic signed [34:0]      d_reg;
    logic                    zero_reg;
    logic signed [TOT_W-1:0] total;
    logic [TOT_W-9:0]        quot;

    always_ff @(posedge aclk) begin
        if (load) begin
            p_reg    <= $signed({1'b0, cfg.prop_gain}) * mid.err;
            i_reg    <= $signed({1'b0, cfg.integ_gain_dt}) * mid.esum;
            d_reg    <= $signed({1'b0, cfg.deriv_gain_dt}) * mid.diff;
            zero_reg <= mid.zero_duty;
        end
    end

    always_comb begin
        total = TOT_W'(p_reg) + TOT_W'(i_reg) + TOT_W'(d_reg)
              + $signed({14'd0, cfg.base_duty, 8'd0});
        quot  = total[TOT_W-1:8];
        if (zero_reg || total <= 0) begin
            duty = '0;
        end else if (quot > (TOT_W-8)'(cfg.duty_max)) begin
            duty = cfg.duty_max;
        end else begin
            duty = quot[15:0];
        end
    end

endmodule

@@ hw/rtl/four_channel_pid_speed_control.sv @@
// Top level of the multi-motor PID speed regulator.
// Depends on fcpid_pkg, fcpid_state, fcpid_duty and the assertion macro header.
//
// Usage:
//   The input channel (s_*) takes one request beat per cycle while s_ready
//   is high. An update beat names a motor, a signed target and the raw encoder
//   count of the period; it yields one result beat. A stop-all beat yields
//   one result beat per motor, in motor order, with m_last_result set on the
//   final one. The result channel (m_*) carries motor, duty, H-bridge pin
//   levels, the polarity-corrected count and the last flag. Updates naming a
//   motor at or beyond NUM_MOTORS are dropped without a result.
//   Registers are written through cfg_wr_en/cfg_index/cfg_wdata with no wait;
//   write them only while no request is in flight.
//   Throughput: one update beat per cycle while the pipeline is not stalled;
//   a stop-all holds the input register until it emits one result per motor.
//   Pipeline: input register, state update stage, multiplier stage, output
//   register. Each stage advances when the one after it is empty or moving,
//   so a stalled receiver fills the pipeline before s_ready drops.
//   Reset clears all motor history, points every motor forward and loads the
//   register defaults; the block takes beats in the first cycle after reset.
module four_channel_pid_speed_control
    import fcpid_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [1:0]         s_motor_index,
    input  logic signed [15:0] s_target_speed,
    input  logic signed [15:0] s_encoder_count,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_out_motor,
    output logic [15:0]        m_duty,
    output logic               m_bridge_in1,
    output logic               m_bridge_in2,
    output logic signed [15:0] m_signed_count,
    output logic               m_last_result,

    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain     <= PROP_GAIN_RST;
            cfg_reg.integ_gain_dt <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain_dt <= DERIV_GAIN_RST;
            cfg_reg.base_duty     <= BASE_DUTY_RST;
            cfg_reg.duty_max      <= DUTY_MAX_RST;
            cfg_reg.integ_limit   <= INTEG_LIMIT_RST;
            cfg_reg.enc_flip      <= ENC_FLIP_RST;
            cfg_reg.brg_flip      <= BRG_FLIP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_wdata;
                REG_INTEG_GAIN_DT: cfg_reg.integ_gain_dt <= cfg_wdata;
                REG_DERIV_GAIN_DT: cfg_reg.deriv_gain_dt <= cfg_wdata;
                REG_BASE_DUTY:     cfg_reg.base_duty     <= cfg_wdata;
                REG_DUTY_MAX:      cfg_reg.duty_max      <= cfg_wdata;
                REG_INTEG_LIMIT:   cfg_reg.integ_limit   <= cfg_wdata[14:0];
                REG_ENC_FLIP_MASK: cfg_reg.enc_flip      <= cfg_wdata[3:0];
                REG_BRG_FLIP_MASK: cfg_reg.brg_flip      <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Input register and stop-all sequencing.
    logic               in_vld_reg;
    logic               req_reg;
    logic [1:0]         idx_reg;
    logic signed [15:0] tgt_reg;
    logic signed [15:0] cnt_reg;
    logic [IDX_W-1:0]   stop_cnt_reg;
    logic [IDX_W-1:0]   stop_cnt_next;

    // Pipeline valid bits and payloads.
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic m_vld_reg;
    mid_t mid_next;
    mid_t s1_reg;

    logic [1:0]         s2_motor_reg;
    logic               s2_in1_reg;
    logic signed [15:0] s2_count_reg;
    logic               s2_last_reg;

    logic [1:0]         out_motor_reg;
    logic [15:0]        out_duty_reg;
    logic               out_in1_reg;
    logic signed [15:0] out_count_reg;
    logic               out_last_reg;

    logic        in_range;
    logic        is_stop;
    logic        stop_last;
    logic        out_en;
    logic        s2_en;
    logic        s1_en;
    logic        emit;
    logic        pop;
    logic [15:0] duty_calc;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        is_stop   = (req_reg != 1'(REQ_UPDATE));
        in_range  = (MOTOR_CNT_W'(idx_reg) < MOTOR_CNT_W'(NUM_MOTORS));
        stop_last = (stop_cnt_reg == IDX_W'(NUM_MOTORS - 1));
        out_en    = ~m_vld_reg | m_ready;
        s2_en     = ~s2_vld_reg | out_en;
        s1_en     = ~s1_vld_reg | s2_en;
        emit      = in_vld_reg & s1_en & (is_stop | in_range);
        pop       = in_vld_reg & s1_en & (~is_stop | stop_last);
        s_ready   = ~in_vld_reg | pop;

        stop_cnt_next = stop_cnt_reg;
        if (emit && is_stop) begin
            stop_cnt_next = stop_last ? '0 : stop_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            stop_cnt_reg <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            stop_cnt_reg <= stop_cnt_next;
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (pop) begin
                in_vld_reg <= 1'b0;
            end
            if (s1_en) begin
                s1_vld_reg <= emit;
            end
            if (s2_en) begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (out_en) begin
                m_vld_reg <= s2_vld_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req_type;
            idx_reg <= s_motor_index;
            tgt_reg <= s_target_speed;
            cnt_reg <= s_encoder_count;
        end
        if (s1_en) begin
            s1_reg <= mid_next;
        end
        if (s2_en) begin
            s2_motor_reg <= s1_reg.motor;
            s2_in1_reg   <= s1_reg.in1;
            s2_count_reg <= s1_reg.count;
            s2_last_reg  <= s1_reg.last;
        end
        if (out_en) begin
            out_motor_reg <= s2_motor_reg;
            out_duty_reg  <= duty_calc;
            out_in1_reg   <= s2_in1_reg;
            out_count_reg <= s2_count_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    // Motor state is read and written in the same cycle the request leaves
    // the input register, so back-to-back updates of one motor see each
    // other's history.
    fcpid_state #(
        .NUM_MOTORS (NUM_MOTORS),
        .IDX_W      (IDX_W)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (emit),
        .stop      (is_stop),
        .stop_last (stop_last),
        .stop_idx  (stop_cnt_reg),
        .motor     (idx_reg),
        .target    (tgt_reg),
        .count     (cnt_reg),
        .cfg       (cfg_reg),
        .mid       (mid_next)
    );

    // Gains multiply in the second stage; the sum and clamp feed the
    // output register.
    fcpid_duty u_duty (
        .aclk (aclk),
        .load (s2_en),
        .mid  (s1_reg),
        .cfg  (cfg_reg),
        .duty (duty_calc)
    );

    assign m_valid        = m_vld_reg;
    assign m_out_motor    = out_motor_reg;
    assign m_duty         = out_duty_reg;
    assign m_bridge_in1   = out_in1_reg;
    assign m_bridge_in2   = ~out_in1_reg;
    assign m_signed_count = out_count_reg;
    assign m_last_result  = out_last_reg;

`include "four_channel_pid_speed_control_assert.svh"

    `FCPID_ASSERT_SAME(a_stop_cnt_idle, !in_vld_reg, stop_cnt_reg == '0,
        "stop sequence counter left nonzero with no request held")

    `FCPID_ASSERT_SAME(a_stop_cnt_owner, stop_cnt_reg != '0, in_vld_reg && is_stop,
        "stop sequence counter running without a stop-all request")

    `FCPID_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, in_vld_reg,
        "accepted request beat not held in the input register")

    `FCPID_ASSERT_SAME(a_non_last_is_stop, m_valid && !m_last_result,
        m_duty == 16'd0 && m_signed_count == 16'sd0,
        "non-final result beat is not a stop-all result")

endmodule
